[design/ifsn_pkg.sv]
// Shared types and constants of the symmetric-numerator IIR filter.
// No dependencies; imported by ifsn_mac and the filter core.
package ifsn_pkg;

    localparam int DEF_MAX_ZEROS = 32;
    localparam int DEF_MAX_POLES = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ZEROS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_POLES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_SCALE = 2'd2;

    localparam logic [16:0] INPUT_SCALE_RST = 17'd65536;

    // item opcodes
    localparam logic [1:0] OP_SAMPLE   = 2'd0;
    localparam logic [1:0] OP_NUM_COEF = 2'd1;
    localparam logic [1:0] OP_FB_COEF  = 2'd2;

    localparam int DATA_W = 24;
    localparam int PROD_W = 48;
    localparam int XS_W   = 18;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [5:0]         coef_index;
        logic signed [23:0] coef_value;
        logic signed [15:0] sample_in;
        logic               block_end;
    } t_in_beat;

    typedef struct packed {
        logic signed [23:0] filtered;
        logic               saturated;
        logic               block_end_out;
    } t_out_beat;

    typedef struct packed {
        logic mul_en;
        logic acc_clr;
        logic acc_en;
    } t_mac_ctl;

endpackage

[design/ifsn_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module ifsn_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/ifsn_mac.sv]
// Shared 24x24 multiplier, product register, accumulator, and output rounding.
// Depends on ifsn_pkg.
module ifsn_mac #(
    parameter int N_TERMS = 49
) (
    input  logic                 i_clk,
    input  ifsn_pkg::t_mac_ctl   i_ctl,
    input  logic signed [23:0]   i_op_a,
    input  logic signed [23:0]   i_op_b,
    output logic signed [17:0]   o_scaled,
    output logic signed [23:0]   o_y,
    output logic                 o_sat
);
    import ifsn_pkg::*;

    localparam int ACCW = PROD_W + $clog2(N_TERMS) + 1;
    localparam logic signed [ACCW-1:0] YMAX = {{(ACCW-24){1'b0}}, 24'h7FFFFF};
    localparam logic signed [ACCW-1:0] YMIN = {{(ACCW-24){1'b1}}, 24'h800000};
    localparam logic signed [ACCW-1:0] RND  = ACCW'(1 << 19);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACCW-1:0]   r_acc;
    logic signed [PROD_W-1:0] scl_sum;
    logic signed [ACCW-1:0]   rnd_sum;
    logic signed [ACCW-1:0]   y_wide;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= i_op_a * i_op_b;
        end
        if (i_ctl.acc_clr) begin
            r_acc <= '0;
        end else if (i_ctl.acc_en) begin
            r_acc <= r_acc + {{(ACCW-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end
    end

    // sample * scale, rounded half up to sample units (Q1.16 scale)
    assign scl_sum  = r_prod + PROD_W'(32768);
    assign o_scaled = scl_sum[33:16];

    // Q.20 sum to sample units, half up, then clip
    assign rnd_sum = r_acc + RND;
    assign y_wide  = rnd_sum >>> 20;

    always_comb begin
        o_sat = 1'b0;
        o_y   = y_wide[23:0];
        if (y_wide > YMAX) begin
            o_y   = 24'sh7FFFFF;
            o_sat = 1'b1;
        end else if (y_wide < YMIN) begin
            o_y   = -24'sd8388608;
            o_sat = 1'b1;
        end
    end

endmodule

[design/iir_filter_symmetric_numerator_core.sv]
// Symmetric-numerator IIR filter core. A sample beat is scaled, then runs one tap per cycle
// through the shared multiplier; the next beat is taken once the result sits in the output
// register. Coefficient beats are written straight to RAM and give no result. Synchronous
// active-low reset clears control and the per-entry valid bits and resets config (input
// scale to 1.0), so all coefficients and histories read as zero at once.
// Depends on ifsn_pkg, ifsn_ram, ifsn_mac.
module iir_filter_symmetric_numerator_core #(
    parameter int MAX_ZEROS = ifsn_pkg::DEF_MAX_ZEROS,
    parameter int MAX_POLES = ifsn_pkg::DEF_MAX_POLES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ifsn_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ifsn_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  ifsn_pkg::t_in_beat                  i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output ifsn_pkg::t_out_beat                 o_out
);
    import ifsn_pkg::*;

    localparam int ZW     = $clog2(MAX_ZEROS + 1);
    localparam int PW     = $clog2(MAX_POLES + 1);
    localparam int CNTW   = (ZW > PW) ? ZW : PW;
    localparam int CDEPTH = MAX_ZEROS + 1 + MAX_POLES;
    localparam int HDEPTH = MAX_ZEROS + MAX_POLES + 2;
    localparam int CAW    = $clog2(CDEPTH);
    localparam int HAW    = $clog2(HDEPTH);
    localparam int CBASE  = MAX_ZEROS + 1;
    localparam int OBASE  = MAX_ZEROS + 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCALE = 3'd1;
    localparam logic [2:0] ST_XLOAD = 3'd2;
    localparam logic [2:0] ST_NUM   = 3'd3;
    localparam logic [2:0] ST_FB    = 3'd4;
    localparam logic [2:0] ST_DRAIN = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [5:0]  r_num_zeros;
    logic [4:0]  r_num_poles;
    logic [16:0] r_input_scale;

    logic [2:0]  r_state, n_state;
    logic [CNTW-1:0] r_cnt;
    logic [ZW-1:0]   r_nz;
    logic [PW-1:0]   r_np;
    logic signed [15:0] r_sample;
    logic        r_blk;
    logic signed [17:0] r_x;

    logic        r_cvalid [CDEPTH];
    logic        r_hvalid [HDEPTH];

    logic        r_b_vld, r_b_use_x, r_b_hv, r_b_cv;
    logic [HAW-1:0] r_b_waddr;
    logic        r_c_vld;

    logic        r_out_vld;
    t_out_beat   r_out;

    logic        in_acc, issue, out_load;
    logic [ZW-1:0] nz_cap, k_lo, k_hi;
    logic [PW-1:0] np_cap;
    logic        c_we;
    logic [CAW-1:0] c_waddr, c_raddr;
    logic [23:0] c_rdata;
    logic        h_we;
    logic [HAW-1:0] h_waddr, h_raddr;
    logic [23:0] h_wdata, h_rdata;
    logic signed [23:0] op_a, op_b, b_a;
    logic signed [17:0] scaled;
    logic signed [23:0] y;
    logic        sat;
    t_mac_ctl    mac_ctl;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign issue      = (r_state == ST_NUM) || (r_state == ST_FB);
    assign out_load   = (r_state == ST_OUT) && (!r_out_vld || !i_out_stall);

    assign nz_cap = (int'(r_num_zeros) > MAX_ZEROS) ? ZW'(MAX_ZEROS) : ZW'(r_num_zeros);
    assign np_cap = (int'(r_num_poles) > MAX_POLES) ? PW'(MAX_POLES) : PW'(r_num_poles);

    // coefficient beats write straight into the coefficient RAM
    always_comb begin
        c_we    = 1'b0;
        c_waddr = CAW'(i_in.coef_index);
        if (in_acc && i_in.opcode == OP_NUM_COEF && int'(i_in.coef_index) <= MAX_ZEROS) begin
            c_we = 1'b1;
        end
        if (in_acc && i_in.opcode == OP_FB_COEF && int'(i_in.coef_index) < MAX_POLES) begin
            c_we    = 1'b1;
            c_waddr = CAW'(CBASE + int'(i_in.coef_index));
        end
    end

    // folded numerator: tap i uses b[min(i, nz - i)]
    assign k_lo = r_cnt[ZW-1:0];
    assign k_hi = r_nz - k_lo;

    always_comb begin
        if (r_state == ST_FB) begin
            c_raddr = CAW'(CBASE + int'(r_cnt));
            h_raddr = HAW'(OBASE + int'(r_cnt) + 1);
        end else begin
            c_raddr = (k_lo <= k_hi) ? CAW'(k_lo) : CAW'(k_hi);
            h_raddr = HAW'(int'(k_lo) + 1);
        end
    end

    // stage B: RAM data back; shifted history entry written one slot down
    assign b_a = r_b_use_x ? 24'(r_x) : (r_b_hv ? $signed(h_rdata) : 24'sd0);

    always_comb begin
        h_we    = r_b_vld;
        h_waddr = r_b_waddr;
        h_wdata = b_a;
        if (out_load) begin
            h_we    = 1'b1;
            h_waddr = HAW'(OBASE + int'(r_np));
            h_wdata = y;
        end
    end

    always_comb begin
        if (r_state == ST_SCALE) begin
            op_a = 24'(r_sample);
            op_b = $signed({7'd0, r_input_scale});
        end else begin
            op_a = b_a;
            op_b = r_b_cv ? $signed(c_rdata) : 24'sd0;
        end
        mac_ctl.mul_en  = (r_state == ST_SCALE) || r_b_vld;
        mac_ctl.acc_clr = (r_state == ST_XLOAD);
        mac_ctl.acc_en  = r_c_vld;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && i_in.opcode == OP_SAMPLE) begin
                    n_state = ST_SCALE;
                end
            end
            ST_SCALE: n_state = ST_XLOAD;
            ST_XLOAD: n_state = ST_NUM;
            ST_NUM: begin
                if (r_cnt == CNTW'(r_nz)) begin
                    n_state = (r_np != '0) ? ST_FB : ST_DRAIN;
                end
            end
            ST_FB: begin
                if (r_cnt == CNTW'(r_np - 1'b1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_b_vld && !r_c_vld) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_zeros   <= '0;
            r_num_poles   <= '0;
            r_input_scale <= INPUT_SCALE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_NUM_ZEROS:   r_num_zeros   <= i_cfg_data[5:0];
                REG_NUM_POLES:   r_num_poles   <= i_cfg_data[4:0];
                REG_INPUT_SCALE: r_input_scale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_b_vld   <= 1'b0;
            r_c_vld   <= 1'b0;
            r_out_vld <= 1'b0;
            for (int i = 0; i < CDEPTH; i++) begin
                r_cvalid[i] <= 1'b0;
            end
            for (int i = 0; i < HDEPTH; i++) begin
                r_hvalid[i] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            r_b_vld <= issue;
            r_c_vld <= r_b_vld;
            if (c_we) begin
                r_cvalid[c_waddr] <= 1'b1;
            end
            if (h_we) begin
                r_hvalid[h_waddr] <= 1'b1;
            end
            if (r_state == ST_NUM && r_cnt == CNTW'(r_nz)) begin
                r_cnt <= '0;
            end else if (issue) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sample <= i_in.sample_in;
            r_blk    <= i_in.block_end;
            r_nz     <= nz_cap;
            r_np     <= np_cap;
        end
        if (r_state == ST_XLOAD) begin
            r_x <= scaled;
        end
        if (issue) begin
            r_b_use_x <= (r_state == ST_NUM) && (r_cnt == CNTW'(r_nz));
            r_b_waddr <= (r_state == ST_FB) ? HAW'(OBASE + int'(r_cnt)) : HAW'(k_lo);
            r_b_hv    <= r_hvalid[h_raddr];
            r_b_cv    <= r_cvalid[c_raddr];
        end
        if (out_load) begin
            r_out.filtered      <= y;
            r_out.saturated     <= sat;
            r_out.block_end_out <= r_blk;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    ifsn_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CDEPTH)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (i_in.coef_value),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    ifsn_ram #(
        .WIDTH (DATA_W),
        .DEPTH (HDEPTH)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (h_wdata),
        .i_raddr (h_raddr),
        .o_rdata (h_rdata)
    );

    ifsn_mac #(
        .N_TERMS (CDEPTH)
    ) u_mac (
        .i_clk    (i_clk),
        .i_ctl    (mac_ctl),
        .i_op_a   (op_a),
        .i_op_b   (op_b),
        .o_scaled (scaled),
        .o_y      (y),
        .o_sat    (sat)
    );

`ifndef SYNTHESIS
    // the pipeline must be empty before the sum is rounded
    a_drained_at_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |-> (!r_b_vld && !r_c_vld))
        else $error("accumulator read while taps still in flight");

    // write-back of a shifted entry never hits the entry being read
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && r_b_vld) |-> (r_b_waddr != h_raddr))
        else $error("history read and write-back on the same entry");

    a_num_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_NUM) |-> (r_cnt <= CNTW'(r_nz)))
        else $error("numerator tap counter past order");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (o_out_valid && r_state == ST_IDLE))
        else $error("result not presented after finishing a sample");
`endif

endmodule
